@@ sv/nkt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package nkt_pkg;

  // Default table geometry.
  localparam int NODES_DEF    = 16;
  localparam int ID_BITS_DEF  = 64;
  localparam int KEY_BITS_DEF = 64;

  // Fixed port widths.
  localparam int ID_W     = 64;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 5;

  // Reset value of the usable entry count.
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // capture the input item and reset the search
    logic issue;     // read the entry at the scan index
    logic check;     // compare the entry just read
    logic advance;   // move the scan index to the next entry
    logic write;     // store the entry for a write item
    logic load_out;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;    // no entry is usable
    logic last;      // scan index is at the last usable entry
    logic match;     // entry just read holds the requested ID pair
    logic is_read;   // current item is a lookup
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

@@ sv/nkt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nkt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/nkt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nkt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire nkt_pkg::sts_t sts,
  output nkt_pkg::cmd_t      cmd
);

  import nkt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ISSUE  = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_WRITE  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // The input side is open only between items.
  assign in_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.n_zero ? S_RESULT : S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.match || sts.last) begin
          state_next = sts.is_read ? S_RESULT : S_WRITE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_ISSUE;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/nkt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module nkt_datapath #(
  parameter int NODES    = nkt_pkg::NODES_DEF,
  parameter int ID_BITS  = nkt_pkg::ID_BITS_DEF,
  parameter int KEY_BITS = nkt_pkg::KEY_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire nkt_pkg::cmd_t                    cmd,
  output nkt_pkg::sts_t                         sts,
  input  wire logic                             cfg_we,
  input  wire logic [nkt_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                             action,
  input  wire logic [nkt_pkg::ID_W-1:0]         client_id,
  input  wire logic [nkt_pkg::ID_W-1:0]         server_id,
  input  wire logic [nkt_pkg::KEY_W-1:0]        new_key,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [nkt_pkg::STATUS_W-1:0]     status,
  output logic      [nkt_pkg::KEY_W-1:0]        found_key
);

  import nkt_pkg::*;

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNT_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
  localparam int ENT_W = 2 * ID_BITS + KEY_BITS;
  localparam logic [CNT_W-1:0] NODES_CNT = CNT_W'(NODES);

  logic [CFG_W-1:0]    entries_in_use;
  logic                is_read;
  logic [ID_BITS-1:0]  cid;
  logic [ID_BITS-1:0]  sid;
  logic [KEY_BITS-1:0] key;
  logic [IDX_W-1:0]    idx;
  logic                hit;
  logic                empty_seen;
  logic [IDX_W-1:0]    empty_idx;
  logic [KEY_BITS-1:0] found;
  logic                ent_valid;
  logic [NODES-1:0]    valid;

  logic [CNT_W-1:0]    usable;
  logic [CNT_W-1:0]    cfg_ext;
  logic [ENT_W-1:0]    rdata;
  logic [ID_BITS-1:0]  r_cid;
  logic [ID_BITS-1:0]  r_sid;
  logic [KEY_BITS-1:0] r_key;
  logic                entry_match;
  logic                entry_empty;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [STATUS_W-1:0] status_next;

  // Usable entry count, saturated to the table size.
  assign cfg_ext = CNT_W'(entries_in_use);
  assign usable  = (cfg_ext > NODES_CNT) ? NODES_CNT : cfg_ext;

  // Entry store: client ID, server ID and key side by side.
  nkt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODES),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({cid, sid, key}),
    .raddr(idx),
    .rdata(rdata)
  );

  assign r_cid = rdata[ENT_W-1 -: ID_BITS];
  assign r_sid = rdata[KEY_BITS +: ID_BITS];
  assign r_key = rdata[KEY_BITS-1:0];

  // An entry never written since reset reads as all zero.
  assign entry_match = ent_valid ? ((r_cid == cid) && (r_sid == sid))
                                 : ((cid == '0) && (sid == '0));
  assign entry_empty = !ent_valid || (rdata == '0);

  // A write goes to the matching entry, else to the first empty one.
  assign ram_we    = cmd.write && (hit || empty_seen);
  assign ram_waddr = hit ? idx : empty_idx;

  // Status toward the controller.
  assign sts.n_zero   = (usable == '0);
  assign sts.last     = ((CNT_W'(idx) + CNT_W'(1)) == usable);
  assign sts.match    = entry_match;
  assign sts.is_read  = is_read;
  assign sts.out_free = !out_valid || !out_stall;

  // Result code of the finished search.
  always_comb begin
    if (is_read) begin
      status_next = hit ? ST_FOUND : ST_NOT_FOUND;
    end else if (hit) begin
      status_next = ST_UPDATED;
    end else if (empty_seen) begin
      status_next = ST_INSERTED;
    end else begin
      status_next = ST_FULL;
    end
  end

  // Control state: register, valid bits, search flags and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CFG_RESET;
      valid          <= '0;
      hit            <= 1'b0;
      empty_seen     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        entries_in_use <= cfg_wdata;
      end
      if (cmd.start) begin
        hit        <= 1'b0;
        empty_seen <= 1'b0;
      end else if (cmd.check) begin
        if (entry_match) begin
          hit <= 1'b1;
        end else if (entry_empty) begin
          empty_seen <= 1'b1;
        end
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      is_read <= (action == ACT_READ);
      cid     <= client_id[ID_BITS-1:0];
      sid     <= server_id[ID_BITS-1:0];
      key     <= new_key[KEY_BITS-1:0];
      idx     <= '0;
      found   <= '0;
    end else if (cmd.advance) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.issue) begin
      ent_valid <= valid[idx];
    end
    // Only the first empty entry is kept.
    if (cmd.check && !entry_match && entry_empty && !empty_seen) begin
      empty_idx <= idx;
    end
    if (cmd.check && entry_match) begin
      found <= ent_valid ? r_key : '0;
    end
    if (cmd.load_out) begin
      status    <= status_next;
      found_key <= (is_read && hit) ? KEY_W'(found) : '0;
    end
  end

endmodule

`default_nettype wire

@@ sv/node_key_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Node key table: entries keyed by a client ID and server ID pair, each
// holding key data.
// Input channel: in_valid / in_stall carry action, client_id, server_id and
// new_key. A write (action 0) updates the matching entry or fills the first
// empty entry; a read (action 1) looks the pair up.
// Output channel: out_valid / out_stall carry status and found_key, one
// result per input transfer, in order.
// Configuration: cfg_we with cfg_wdata sets the number of usable entries;
// write it only while no item is in flight.
// Timing: an item is searched one entry at a time, a registered table read
// and then a compare per entry, until a match or the last usable entry; a
// write then stores the entry in a further state. The single table read
// port serves one item at a time: a new input is taken only after the
// previous item has loaded its result.
// A new input can be taken while the previous result still waits in the
// output register; a stalled result holds until it is transferred.
// Reset marks every entry empty at once, sets the usable count to 16 and
// empties the output register.
module node_key_table_top #(
  parameter int NODES    = nkt_pkg::NODES_DEF,
  parameter int ID_BITS  = nkt_pkg::ID_BITS_DEF,
  parameter int KEY_BITS = nkt_pkg::KEY_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [nkt_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         action,
  input  wire logic [nkt_pkg::ID_W-1:0]     client_id,
  input  wire logic [nkt_pkg::ID_W-1:0]     server_id,
  input  wire logic [nkt_pkg::KEY_W-1:0]    new_key,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [nkt_pkg::STATUS_W-1:0] status,
  output logic      [nkt_pkg::KEY_W-1:0]    found_key
);

  import nkt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer of the scan.
  nkt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Table store, compare logic and result register.
  nkt_datapath #(
    .NODES   (NODES),
    .ID_BITS (ID_BITS),
    .KEY_BITS(KEY_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .action   (action),
    .client_id(client_id),
    .server_id(server_id),
    .new_key  (new_key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .found_key(found_key)
  );

  // An accepted item always keeps the input side closed for the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input side open right after a transfer");

  // A result only appears at the end of a search.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

  // Key data is returned only with a found status.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_FOUND)) |-> (found_key == '0))
    else $error("nonzero key without found status");

  // Status codes stay within the defined set.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_NOT_FOUND))
    else $error("undefined status code");

endmodule

`default_nettype wire
